FILE: rtl/core/sackw_pkg.sv
package sackw_pkg;

  localparam int unsigned WINDOW_BITS = 32;
  localparam int unsigned IDX_W       = $clog2(WINDOW_BITS);
  localparam int unsigned CNT_W       = $clog2(WINDOW_BITS + 1);
  localparam int unsigned SEQ_W       = 32;
  localparam int unsigned ACK_MAP_W   = 32;
  localparam int unsigned BATCH_W     = 8;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned VERDICT_W   = 3;
  localparam int unsigned IN_DATA_W   = 40;
  localparam int unsigned OUT_DATA_W  = 72;

  localparam logic [OP_W-1:0] OP_RELIABLE   = 2'd0;
  localparam logic [OP_W-1:0] OP_UNRELIABLE = 2'd1;
  localparam logic [OP_W-1:0] OP_POLL       = 2'd2;

  localparam logic [VERDICT_W-1:0] V_ACCEPT  = 3'd0;
  localparam logic [VERDICT_W-1:0] V_OLD_DUP = 3'd1;
  localparam logic [VERDICT_W-1:0] V_WIN_DUP = 3'd2;
  localparam logic [VERDICT_W-1:0] V_OUT_WIN = 3'd3;
  localparam logic [VERDICT_W-1:0] V_UNREL   = 3'd4;
  localparam logic [VERDICT_W-1:0] V_POLL    = 3'd5;

  localparam logic [BATCH_W-1:0] BATCH_RESET = 8'd4;
  localparam logic [BATCH_W-1:0] COUNT_MAX   = 8'd255;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [SEQ_W-1:0] frame_seq;
    logic             ack_allowed;
  } item_t;

  typedef struct packed {
    logic                 deliver;
    logic [VERDICT_W-1:0] verdict;
    logic                 ack_valid;
    logic [SEQ_W-1:0]     ack_contig_seq;
    logic [ACK_MAP_W-1:0] ack_bitmap;
  } result_t;

  function automatic logic [CNT_W-1:0] trailing_ones(input logic [WINDOW_BITS-1:0] b);
    logic [CNT_W-1:0] n;
    n = CNT_W'(WINDOW_BITS);
    for (int i = WINDOW_BITS - 1; i >= 0; i--) begin
      if (!b[i]) n = CNT_W'(i);
    end
    return n;
  endfunction

endpackage

FILE: rtl/core/sackw_in_reg.sv
module sackw_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  sackw_pkg::item_t item_i,
  output logic           valid_o,
  input  logic           ready_i,
  output sackw_pkg::item_t item_o
);

  logic             valid_q;
  sackw_pkg::item_t item_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

endmodule

FILE: rtl/core/sackw_engine.sv
module sackw_engine (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sackw_pkg::BATCH_W-1:0]   cfg_wdata_i,
  input  logic                            fire_i,
  input  sackw_pkg::item_t                item_i,
  output sackw_pkg::result_t              result_o
);

  logic [sackw_pkg::SEQ_W-1:0]       contig_q, contig_d;
  logic [sackw_pkg::WINDOW_BITS-1:0] bits_q, bits_d;
  logic                              owed_q, owed_d;
  logic [sackw_pkg::BATCH_W-1:0]     count_q, count_d;
  logic [sackw_pkg::BATCH_W-1:0]     batch_q;

  logic [sackw_pkg::SEQ_W-1:0]       gap;
  logic [sackw_pkg::IDX_W-1:0]       gap_idx;
  logic [sackw_pkg::WINDOW_BITS-1:0] set_bits;
  logic [sackw_pkg::CNT_W-1:0]       ones;
  logic [sackw_pkg::BATCH_W-1:0]     count_inc;
  logic                              counted;
  logic                              emit;

  assign gap       = item_i.frame_seq - contig_q - 32'd1;
  assign gap_idx   = gap[sackw_pkg::IDX_W-1:0];
  assign set_bits  = bits_q | (sackw_pkg::WINDOW_BITS'(1) << gap_idx);
  assign ones      = sackw_pkg::trailing_ones(set_bits);
  assign count_inc = (count_q == sackw_pkg::COUNT_MAX) ? count_q : count_q + 8'd1;

  always_comb begin
    contig_d = contig_q;
    bits_d   = bits_q;
    owed_d   = owed_q;
    count_d  = count_q;
    counted  = 1'b0;
    emit     = 1'b0;
    result_o = '0;
    case (item_i.operation)
      sackw_pkg::OP_UNRELIABLE: begin
        result_o.deliver = 1'b1;
        result_o.verdict = sackw_pkg::V_UNREL;
      end
      sackw_pkg::OP_RELIABLE: begin
        if (item_i.frame_seq <= contig_q) begin
          result_o.verdict = sackw_pkg::V_OLD_DUP;
          counted          = 1'b1;
        end else if (gap >= sackw_pkg::SEQ_W'(sackw_pkg::WINDOW_BITS)) begin
          result_o.verdict = sackw_pkg::V_OUT_WIN;
          owed_d           = 1'b1;
          emit             = item_i.ack_allowed;
        end else if (bits_q[gap_idx]) begin
          result_o.verdict = sackw_pkg::V_WIN_DUP;
          counted          = 1'b1;
        end else begin
          result_o.deliver = 1'b1;
          result_o.verdict = sackw_pkg::V_ACCEPT;
          counted          = 1'b1;
          contig_d         = contig_q + sackw_pkg::SEQ_W'(ones);
          if (ones == sackw_pkg::CNT_W'(sackw_pkg::WINDOW_BITS)) begin
            bits_d = '0;
          end else begin
            bits_d = set_bits >> ones;
          end
        end
      end
      default: begin
        result_o.verdict = sackw_pkg::V_POLL;
        emit             = owed_q && item_i.ack_allowed;
      end
    endcase
    if (counted) begin
      owed_d  = 1'b1;
      count_d = count_inc;
      emit    = item_i.ack_allowed && (count_inc >= batch_q);
    end
    if (emit) begin
      owed_d                  = 1'b0;
      count_d                 = '0;
      result_o.ack_valid      = 1'b1;
      result_o.ack_contig_seq = contig_d;
      result_o.ack_bitmap     = sackw_pkg::ACK_MAP_W'(bits_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      contig_q <= '0;
      bits_q   <= '0;
      owed_q   <= 1'b0;
      count_q  <= '0;
    end else if (fire_i) begin
      contig_q <= contig_d;
      bits_q   <= bits_d;
      owed_q   <= owed_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      batch_q <= sackw_pkg::BATCH_RESET;
    end else if (cfg_we_i) begin
      batch_q <= cfg_wdata_i;
    end
  end

endmodule

FILE: rtl/core/sackw_out_reg.sv
module sackw_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  sackw_pkg::result_t result_i,
  output logic               valid_o,
  input  logic               ready_i,
  output sackw_pkg::result_t result_o
);

  logic               valid_q;
  sackw_pkg::result_t result_q;

  assign ready_o  = !valid_q || ready_i;
  assign valid_o  = valid_q;
  assign result_o = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      result_q <= result_i;
    end
  end

endmodule

FILE: rtl/core/sack_receive_window.sv
// Receive window with selective acknowledgement.
// Slave stream: one beat per arriving frame or poll. tuser carries the
// operation, tdata the frame sequence number and the ack-allowed flag.
// Master stream: exactly one result beat per input beat, in order. tuser
// carries the verdict, tdata the deliver flag and the acknowledgement fields
// (zero when no acknowledgement goes out).
// Configuration: cfg_we_i writes the acknowledgement batch size from
// cfg_wdata_i; write only while the block is idle.
// The input register holds an accepted beat; the window update writes its
// result into the result register. Throughput: one beat per cycle unless
// the master stalls; the window update, trailing-ones count and bitmap
// shift of one frame fit between those two registers.
// Reset clears the window, the contiguous number, the owed flag and the
// batch counter, and sets the batch size to 4. No stage holds valid data.
// When the master side stalls, the result register holds its beat, the input
// register fills, and then s_axis_tready drops; nothing is lost.
module sack_receive_window (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [sackw_pkg::BATCH_W-1:0]        cfg_wdata_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [31:0] frame_seq, [32] ack_allowed, [39:33] zero
  input  logic [sackw_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // [1:0] operation
  input  logic [sackw_pkg::OP_W-1:0]           s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [0] deliver, [1] ack_valid, [33:2] ack_contig_seq, [65:34] ack_bitmap,
  // [71:66] zero
  output logic [sackw_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // [2:0] verdict
  output logic [sackw_pkg::VERDICT_W-1:0]      m_axis_tuser
);

  sackw_pkg::item_t   in_item;
  sackw_pkg::item_t   stage_item;
  sackw_pkg::result_t stage_result;
  sackw_pkg::result_t out_result;
  logic               stage_valid;
  logic               out_ready;

  assign in_item.operation   = s_axis_tuser;
  assign in_item.frame_seq   = s_axis_tdata[31:0];
  assign in_item.ack_allowed = s_axis_tdata[32];

  sackw_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (in_item),
    .valid_o (stage_valid),
    .ready_i (out_ready),
    .item_o  (stage_item)
  );

  sackw_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (stage_valid && out_ready),
    .item_i      (stage_item),
    .result_o    (stage_result)
  );

  sackw_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (stage_valid),
    .ready_o  (out_ready),
    .result_i (stage_result),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .result_o (out_result)
  );

  assign m_axis_tdata = {6'd0, out_result.ack_bitmap, out_result.ack_contig_seq,
                         out_result.ack_valid, out_result.deliver};
  assign m_axis_tuser = out_result.verdict;

endmodule

FILE: sim/testbench.sv
module testbench;
  import sackw_pkg::*;

  localparam logic [OP_W-1:0] OP_UNKNOWN     = 2'd3;
  localparam int              WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic [OP_W-1:0]  op;
    logic [SEQ_W-1:0] seq;
    logic             allowed;
    bit               fixed;
    result_t          res;
  } dir_row_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [BATCH_W-1:0]    cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [OP_W-1:0]       s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [VERDICT_W-1:0]  m_axis_tuser;

  logic [SEQ_W-1:0]       win_contig;
  logic [WINDOW_BITS-1:0] win_bits;
  logic                   ack_owed_q;
  logic [BATCH_W-1:0]     since_ack;
  logic [BATCH_W-1:0]     batch_size;

  result_t  pending_results[$];
  dir_row_t dir_rows[$];
  result_t  got;
  result_t  want;
  bit       quiet       = 1'b0;
  int       errors      = 0;
  int       out_beats   = 0;
  int       stall_left  = 0;
  int       idle_cycles = 0;
  int       sat_runs    = 0;

  sack_receive_window DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #6 clk_i = ~clk_i;

  function automatic result_t step_window(input logic [OP_W-1:0] op,
                                          input logic [SEQ_W-1:0] seq,
                                          input logic allowed);
    result_t    r;
    logic [31:0] gap;
    bit         counted;
    bit         emit;
    r = '0;
    counted = 1'b0;
    emit = 1'b0;
    if (op == OP_UNRELIABLE) begin
      r.deliver = 1'b1;
      r.verdict = V_UNREL;
    end else if (op != OP_RELIABLE) begin
      r.verdict = V_POLL;
      emit = ack_owed_q && allowed;
    end else if (seq <= win_contig) begin
      r.verdict = V_OLD_DUP;
      counted = 1'b1;
    end else begin
      gap = seq - win_contig - 32'd1;
      if (gap >= WINDOW_BITS) begin
        r.verdict = V_OUT_WIN;
        ack_owed_q = 1'b1;
        emit = allowed;
      end else if (win_bits[gap[IDX_W-1:0]]) begin
        r.verdict = V_WIN_DUP;
        counted = 1'b1;
      end else begin
        win_bits[gap[IDX_W-1:0]] = 1'b1;
        for (int n = 0; n < WINDOW_BITS; n++) begin
          if (win_bits[0]) begin
            win_bits = win_bits >> 1;
            win_contig = win_contig + 32'd1;
          end
        end
        r.deliver = 1'b1;
        r.verdict = V_ACCEPT;
        counted = 1'b1;
      end
    end
    if (counted) begin
      ack_owed_q = 1'b1;
      if (since_ack != COUNT_MAX) since_ack = since_ack + 8'd1;
      emit = allowed && (since_ack >= batch_size);
    end
    if (emit) begin
      ack_owed_q = 1'b0;
      since_ack = '0;
      r.ack_valid = 1'b1;
      r.ack_contig_seq = win_contig;
      r.ack_bitmap = win_bits;
    end
    return r;
  endfunction

  function automatic void add_row(input logic [OP_W-1:0] op, input logic [SEQ_W-1:0] seq,
                                  input logic allowed, input bit fixed,
                                  input logic deliver, input logic [VERDICT_W-1:0] verdict,
                                  input logic ack_v);
    dir_row_t row;
    row.op = op;
    row.seq = seq;
    row.allowed = allowed;
    row.fixed = fixed;
    row.res = '0;
    row.res.deliver = deliver;
    row.res.verdict = verdict;
    row.res.ack_valid = ack_v;
    dir_rows = {dir_rows, row};
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got_v,
                                 input logic [31:0] want_v);
    $display("MISMATCH beat %0d %s: got %h expected %h", out_beats, field, got_v, want_v);
    errors++;
  endtask

  task automatic send_beat(input logic [OP_W-1:0] op, input logic [SEQ_W-1:0] seq,
                           input logic allowed, input bit fixed, input result_t fixed_res);
    int      gap;
    result_t predicted;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= IN_DATA_W'({allowed, seq});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = step_window(op, seq, allowed);
    if (fixed) predicted = fixed_res;
    pending_results = {pending_results, predicted};
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_batch(input logic [BATCH_W-1:0] value);
    drain();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    batch_size = value;
  endtask

  task automatic run_random(input int n_items);
    int          sent;
    int          pick;
    int          k;
    int          j;
    int          tmp;
    int          offs[31];
    logic [31:0] base;
    logic [OP_W-1:0] op;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        k = $urandom_range(2, 12);
        repeat (k) begin
          send_beat(OP_RELIABLE, win_contig + 32'd1 + $urandom_range(0, k + 2),
                    $urandom_range(0, 9) < 8, 1'b0, '0);
        end
        sent += k;
      end else if (pick < 47) begin
        // fill the window out of order, then close the hole at its base
        base = win_contig;
        for (int i = 0; i < 31; i++) offs[i] = i + 2;
        for (int i = 30; i > 0; i--) begin
          j = $urandom_range(0, i);
          tmp = offs[i];
          offs[i] = offs[j];
          offs[j] = tmp;
        end
        for (int i = 0; i < 31; i++) begin
          send_beat(OP_RELIABLE, base + offs[i], $urandom_range(0, 9) < 8, 1'b0, '0);
        end
        send_beat(OP_RELIABLE, base + 32'd1, 1'($urandom_range(0, 1)), 1'b0, '0);
        sent += 32;
      end else if (pick < 57) begin
        send_beat(OP_RELIABLE, $urandom_range(0, win_contig), $urandom_range(0, 9) < 7,
                  1'b0, '0);
        sent++;
      end else if (pick < 64) begin
        send_beat(OP_RELIABLE, $urandom_range(0, 1) ? $urandom :
                  win_contig + 32'd33 + $urandom_range(0, 64), 1'($urandom_range(0, 1)),
                  1'b0, '0);
        sent++;
      end else if (pick < 66) begin
        send_beat(OP_RELIABLE, win_contig + 32'd32 + $urandom_range(0, 1),
                  1'($urandom_range(0, 1)), 1'b0, '0);
        sent++;
      end else if (pick < 76) begin
        send_beat(OP_UNRELIABLE, $urandom, 1'($urandom_range(0, 1)), 1'b0, '0);
        sent++;
      end else if (pick < 88) begin
        op = ($urandom_range(0, 3) == 0) ? OP_UNKNOWN : OP_POLL;
        send_beat(op, $urandom, $urandom_range(0, 9) < 7, 1'b0, '0);
        sent++;
      end else if (pick < 89 && sat_runs < 3) begin
        // hold off acks long enough to saturate the batch counter
        repeat (260) send_beat(OP_RELIABLE, $urandom_range(0, win_contig), 1'b0, 1'b0, '0);
        send_beat(OP_RELIABLE, $urandom_range(0, win_contig), 1'b1, 1'b0, '0);
        sat_runs++;
        sent += 261;
      end else begin
        send_beat(OP_W'($urandom_range(0, 3)), $urandom, 1'($urandom_range(0, 1)), 1'b0,
                  '0);
        sent++;
      end
    end
  endtask

  always @(negedge clk_i) begin
    if (quiet) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      stall_left = pick_gap();
      m_axis_tready <= (stall_left == 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.deliver        = m_axis_tdata[0];
      got.ack_valid      = m_axis_tdata[1];
      got.ack_contig_seq = m_axis_tdata[33:2];
      got.ack_bitmap     = m_axis_tdata[65:34];
      got.verdict        = m_axis_tuser;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat", 32'd1, 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (got.deliver !== want.deliver)
          report_mismatch("deliver", 32'(got.deliver), 32'(want.deliver));
        if (got.verdict !== want.verdict)
          report_mismatch("verdict", 32'(got.verdict), 32'(want.verdict));
        if (got.ack_valid !== want.ack_valid)
          report_mismatch("ack_valid", 32'(got.ack_valid), 32'(want.ack_valid));
        if (got.ack_contig_seq !== want.ack_contig_seq)
          report_mismatch("ack_contig_seq", got.ack_contig_seq, want.ack_contig_seq);
        if (got.ack_bitmap !== want.ack_bitmap)
          report_mismatch("ack_bitmap", got.ack_bitmap, want.ack_bitmap);
      end
      out_beats++;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    win_contig = '0;
    win_bits   = '0;
    ack_owed_q = 1'b0;
    since_ack  = '0;
    batch_size = BATCH_RESET;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    add_row(OP_UNRELIABLE, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, V_UNREL, 1'b0);
    add_row(OP_POLL, 32'h0, 1'b1, 1'b1, 1'b0, V_POLL, 1'b0);
    add_row(OP_UNKNOWN, 32'h0, 1'b1, 1'b1, 1'b0, V_POLL, 1'b0);
    add_row(OP_RELIABLE, 32'h0, 1'b0, 1'b1, 1'b0, V_OLD_DUP, 1'b0);
    add_row(OP_POLL, 32'h0, 1'b1, 1'b1, 1'b0, V_POLL, 1'b1);
    add_row(OP_RELIABLE, 32'h1, 1'b1, 1'b1, 1'b1, V_ACCEPT, 1'b0);
    add_row(OP_RELIABLE, 32'd3, 1'b1, 1'b0, 1'b0, V_ACCEPT, 1'b0);
    add_row(OP_RELIABLE, 32'd33, 1'b1, 1'b0, 1'b0, V_ACCEPT, 1'b0);
    add_row(OP_RELIABLE, 32'd3, 1'b1, 1'b0, 1'b0, V_ACCEPT, 1'b0);
    add_row(OP_RELIABLE, 32'd34, 1'b1, 1'b0, 1'b0, V_ACCEPT, 1'b0);
    add_row(OP_RELIABLE, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, V_OUT_WIN, 1'b0);
    add_row(OP_POLL, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, V_POLL, 1'b0);
    add_row(OP_POLL, 32'h0, 1'b1, 1'b0, 1'b0, V_POLL, 1'b0);
    add_row(OP_UNKNOWN, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, V_POLL, 1'b0);
    add_row(OP_RELIABLE, 32'd2, 1'b1, 1'b0, 1'b0, V_ACCEPT, 1'b0);
    add_row(OP_RELIABLE, 32'd2, 1'b0, 1'b0, 1'b0, V_ACCEPT, 1'b0);
    add_row(OP_UNRELIABLE, 32'h0, 1'b0, 1'b1, 1'b1, V_UNREL, 1'b0);
    add_row(OP_RELIABLE, 32'h8000_0000, 1'b1, 1'b0, 1'b0, V_ACCEPT, 1'b0);
    add_row(OP_RELIABLE, 32'd3, 1'b1, 1'b0, 1'b0, V_ACCEPT, 1'b0);
    add_row(OP_RELIABLE, 32'd4, 1'b1, 1'b0, 1'b0, V_ACCEPT, 1'b0);
    add_row(OP_RELIABLE, 32'd36, 1'b1, 1'b0, 1'b0, V_ACCEPT, 1'b0);
    add_row(OP_RELIABLE, 32'd37, 1'b1, 1'b0, 1'b0, V_ACCEPT, 1'b0);
    foreach (dir_rows[i])
      send_beat(dir_rows[i].op, dir_rows[i].seq, dir_rows[i].allowed, dir_rows[i].fixed,
                dir_rows[i].res);

    set_batch(8'd1);
    run_random(460);
    set_batch(COUNT_MAX);
    run_random(460);
    set_batch(BATCH_W'($urandom_range(2, 254)));
    run_random(460);
    set_batch(BATCH_RESET);
    quiet = 1'b1;
    run_random(200);
    quiet = 1'b0;
    run_random(260);

    drain();
    repeat (10) @(posedge clk_i);
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
